// File: rtl/get_pkg.sv
// Shared types and constants for the gradient edge threshold block.
// Used by get_front, get_queue, get_back and gradient_edge_threshold.
package get_pkg;

   localparam int PIX_W       = 8;
   localparam int OUT_COL_W   = 10;
   localparam int OUT_ROW_W   = 12;
   localparam int RSP_DATA_W  = 40;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;

   localparam logic [7:0]  THRESHOLD_RESET = 8'd50;
   localparam logic [10:0] WIDTH_RESET     = 11'd1024;
   localparam logic [12:0] HEIGHT_RESET    = 13'd1024;
   localparam logic [7:0]  PIX_MAX         = 8'd255;

   // register indexes on the csr port
   localparam logic [1:0] REG_EDGE_THRESHOLD = 2'd0;
   localparam logic [1:0] REG_IMAGE_WIDTH    = 2'd1;
   localparam logic [1:0] REG_IMAGE_HEIGHT   = 2'd2;

   typedef struct packed {
      logic [OUT_COL_W-1:0] col;
      logic [OUT_ROW_W-1:0] row;
      logic [PIX_W-1:0]     hmag;
      logic [PIX_W-1:0]     vmag;
   } result_type;

   // up to three results caused by one input, slot 0 first
   typedef struct packed {
      logic [1:0]            count;
      result_type [2:0]      res;
   } group_type;

   function automatic logic [PIX_W-1:0] absdiff(input logic [PIX_W-1:0] a,
                                                input logic [PIX_W-1:0] b);
      absdiff = (a >= b) ? (a - b) : (b - a);
   endfunction

endpackage

// File: rtl/get_front.sv
// Front part: pixel counters, two-row line memory, gradient computation.
// Pushes one result group per input below the first row into the queue. Depends on get_pkg.
module get_front #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            restart,
   input  logic [$clog2(MAX_WIDTH)-1:0]    last_col,
   input  logic [$clog2(MAX_HEIGHT)-1:0]   last_row,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [get_pkg::PIX_W-1:0]       pixel,
   output logic                            push_valid,
   input  logic                            push_ready,
   output get_pkg::group_type              push_group
);
   import get_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);
   localparam int AW = $clog2(2 * MAX_WIDTH);

   logic [CW-1:0]    col_ff, col_in;
   logic [RW-1:0]    row_ff, row_in;

   logic [PIX_W-1:0] line_mem [2 * MAX_WIDTH];
   logic [PIX_W-1:0] rd_a_ff, rd_b_ff;
   logic [AW-1:0]    wr_addr, rd_a_addr;
   logic [CW-1:0]    col_plus;

   logic             s1_valid_ff, s1_valid_in;
   logic [PIX_W-1:0] s1_pix_ff;
   logic [CW-1:0]    s1_col_ff;
   logic [RW-1:0]    s1_row_ff;
   logic             s1_above_ff, s1_top_ff, s1_last_ff;
   logic             s1_col0_ff, s1_col1_ff, s1_colw_ff;

   logic [PIX_W-1:0] win_left_ff, win_mid_ff;
   logic [PIX_W-1:0] recent0_ff, recent1_ff;

   logic             accept, s1_adv, second, final_px;
   logic [PIX_W-1:0] hm_a, vm_a, hm_b, vm_b, hm_c, vm_c;
   logic [RW-1:0]    row_up;

   assign accept   = req_tvalid & req_tready;
   assign col_plus = col_ff + 1'b1;

   function automatic logic [AW-1:0] line_addr(input logic bank, input logic [CW-1:0] c);
      line_addr = bank ? (AW'(c) + AW'(MAX_WIDTH)) : AW'(c);
   endfunction

   // the right neighbour of the row above; at the row end prefetch column 0 of this row
   always_comb begin
      wr_addr = line_addr(row_ff[0], col_ff);
      if (col_ff == last_col) begin
         rd_a_addr = line_addr(row_ff[0], '0);
      end else begin
         rd_a_addr = line_addr(~row_ff[0], col_plus);
      end
   end

   // read before write: port b sees the row two above
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_a_ff <= line_mem[rd_a_addr];
         rd_b_ff <= line_mem[wr_addr];
         line_mem[wr_addr] <= pixel;
      end
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (restart) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (col_ff == last_col) begin
            col_in = '0;
            row_in = (row_ff == last_row) ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_plus;
         end
      end
   end

   // results of the staged item
   assign second   = s1_last_ff & ~s1_col0_ff;
   assign final_px = s1_last_ff & s1_colw_ff;
   assign row_up   = s1_row_ff - 1'b1;

   always_comb begin
      priority if (s1_col0_ff) begin
         hm_a = absdiff(rd_a_ff, win_mid_ff);
      end else if (s1_colw_ff) begin
         hm_a = absdiff(win_mid_ff, win_left_ff);
      end else begin
         hm_a = absdiff(rd_a_ff, win_left_ff) >> 1;
      end
      if (s1_top_ff) begin
         vm_a = absdiff(s1_pix_ff, win_mid_ff);
      end else begin
         vm_a = absdiff(s1_pix_ff, rd_b_ff) >> 1;
      end
      if (s1_col1_ff) begin
         hm_b = absdiff(s1_pix_ff, recent0_ff);
      end else begin
         hm_b = absdiff(s1_pix_ff, recent1_ff) >> 1;
      end
      vm_b = absdiff(recent0_ff, win_left_ff);
      hm_c = absdiff(s1_pix_ff, recent0_ff);
      vm_c = absdiff(s1_pix_ff, win_mid_ff);
   end

   always_comb begin
      push_group.count      = 2'(s1_above_ff) + 2'(second) + 2'(final_px);
      push_group.res[0].col  = OUT_COL_W'(s1_col_ff);
      push_group.res[0].row  = OUT_ROW_W'(row_up);
      push_group.res[0].hmag = hm_a;
      push_group.res[0].vmag = vm_a;
      push_group.res[1].col  = OUT_COL_W'(s1_col_ff - 1'b1);
      push_group.res[1].row  = OUT_ROW_W'(s1_row_ff);
      push_group.res[1].hmag = hm_b;
      push_group.res[1].vmag = vm_b;
      push_group.res[2].col  = OUT_COL_W'(s1_col_ff);
      push_group.res[2].row  = OUT_ROW_W'(s1_row_ff);
      push_group.res[2].hmag = hm_c;
      push_group.res[2].vmag = vm_c;
   end

   // first-row items have nothing to push and just drain
   assign push_valid  = s1_valid_ff & s1_above_ff;
   assign s1_adv      = s1_valid_ff & (~s1_above_ff | push_ready);
   assign req_tready  = ~s1_valid_ff | s1_adv;
   assign s1_valid_in = accept | (s1_valid_ff & ~s1_adv);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff   <= pixel;
         s1_col_ff   <= col_ff;
         s1_row_ff   <= row_ff;
         s1_above_ff <= (row_ff != '0);
         s1_top_ff   <= (row_ff == RW'(1));
         s1_last_ff  <= (row_ff == last_row);
         s1_col0_ff  <= (col_ff == '0);
         s1_col1_ff  <= (col_ff == CW'(1));
         s1_colw_ff  <= (col_ff == last_col);
      end
      // slide the window of the row above and the recent pixels of this row
      if (s1_adv) begin
         win_left_ff <= win_mid_ff;
         win_mid_ff  <= rd_a_ff;
         recent1_ff  <= recent0_ff;
         recent0_ff  <= s1_pix_ff;
      end
   end

endmodule

// File: rtl/get_queue.sv
// Short queue of result groups between front and back.
// Depends on get_pkg.
module get_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  get_pkg::group_type push_group,
   output logic               pop_valid,
   input  logic               pop_ready,
   output get_pkg::group_type pop_group
);
   import get_pkg::*;

   group_type         entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              do_push, do_pop;

   assign push_ready = (count_ff != (QPTR_W + 1)'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_group  = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid & push_ready;
   assign do_pop     = pop_valid & pop_ready;

   always_comb begin
      count_in = count_ff;
      if (do_push & ~do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop & ~do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_group;
      end
   end

endmodule

// File: rtl/get_back.sv
// Back part: unpacks a result group one result a cycle while rsp_tready allows,
// applies the threshold and holds the result in the output register. Depends on get_pkg.
module get_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [7:0]                        threshold,
   input  logic                              pop_valid,
   output logic                              pop_ready,
   input  get_pkg::group_type                pop_group,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [get_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                              rsp_tlast
);
   import get_pkg::*;

   group_type             cur_ff;
   logic                  cur_valid_ff;
   logic [1:0]            idx_ff;
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_last_ff;

   result_type            slot;
   logic                  last_slot, out_load, emit, take;
   logic                  eh, ev;

   assign slot      = cur_ff.res[idx_ff];
   assign last_slot = (idx_ff == cur_ff.count - 2'd1);
   assign out_load  = ~rsp_valid_ff | rsp_tready;
   assign emit      = cur_valid_ff & out_load;
   assign pop_ready = ~cur_valid_ff | (emit & last_slot);
   assign take      = pop_valid & pop_ready;

   assign eh = (slot.hmag > threshold);
   assign ev = (slot.vmag > threshold);
   assign rsp_data_in = {7'd0, eh | ev, ev, eh, slot.hmag, slot.row, slot.col};

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            cur_valid_ff <= 1'b1;
            idx_ff       <= '0;
         end else if (emit & last_slot) begin
            cur_valid_ff <= 1'b0;
         end else if (emit) begin
            idx_ff <= idx_ff + 2'd1;
         end
         if (out_load) begin
            rsp_valid_ff <= emit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         cur_ff <= pop_group;
      end
      if (emit) begin
         rsp_data_ff <= rsp_data_in;
         rsp_last_ff <= last_slot;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// File: rtl/gradient_edge_threshold.sv
// Gradient edge threshold detector, top level.
// Streams 8-bit grey pixels in raster order on req_* and returns per-pixel
// horizontal magnitude and edge flags on rsp_*; one pixel a cycle is taken unless stalled.
// Results trail the input by one row: an input in row r >= 1 yields the pixel
// directly above it; inputs of the last row also yield last-row pixels, so the
// final pixel of a frame causes three transfers, and rsp_tlast marks the final
// transfer caused by each input. First-row inputs cause none.
// Path: an accepted input goes through the front stage register, the queue and
// the back's group register to rsp_*; unstalled, its results follow one a cycle.
// Throughput: one input per cycle, set by the single write and two
// read ports of the line memory; in the last row the output side moves one
// result a cycle, so two or three results per input slow intake there.
// A four-group queue parts the front from the output side: when rsp_tready is
// low, intake continues until the queue fills, then req_tready drops.
// csr_*: edge_threshold at 0x0, image_width at 0x4, image_height at 0x8;
// writing a size restarts the frame at pixel (0, 0). Write only while idle.
// Reset sets threshold 50, size 1024 x 1024, and the frame position to (0, 0);
// the line memory is not cleared, as every read hits a pixel of this frame.
module gradient_edge_threshold #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic        clock,
   input  logic        reset,
   // slave side: [7:0] grey_level
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,
   // master side: [9:0] out_col, [21:10] out_row, [29:22] horizontal_magnitude,
   // [30] edge_horizontal, [31] edge_vertical, [32] edge_either, [39:33] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import get_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);

   logic [7:0]    threshold_ff;
   logic [10:0]   width_ff;
   logic [12:0]   height_ff;
   logic          csr_write, restart;
   logic [31:0]   width_sat, height_sat;
   logic [CW-1:0] last_col;
   logic [RW-1:0] last_row;

   logic          q_push_valid, q_push_ready, q_pop_valid, q_pop_ready;
   group_type     q_push_group, q_pop_group;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign restart    = csr_write & ((csr_paddr[3:2] == REG_IMAGE_WIDTH) |
                                    (csr_paddr[3:2] == REG_IMAGE_HEIGHT));

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
         width_ff     <= WIDTH_RESET;
         height_ff    <= HEIGHT_RESET;
      end else if (csr_write) begin
         unique case (csr_paddr[3:2])
            REG_EDGE_THRESHOLD: threshold_ff <= csr_pwdata[7:0];
            REG_IMAGE_WIDTH:    width_ff     <= csr_pwdata[10:0];
            REG_IMAGE_HEIGHT:   height_ff    <= csr_pwdata[12:0];
            default: begin
               // drop writes beyond the register list
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_EDGE_THRESHOLD: csr_prdata = 32'(threshold_ff);
         REG_IMAGE_WIDTH:    csr_prdata = 32'(width_ff);
         REG_IMAGE_HEIGHT:   csr_prdata = 32'(height_ff);
         default:            csr_prdata = '0;
      endcase
   end

   // clamp the frame size to 2..MAX
   always_comb begin
      priority if (width_ff < 11'd2) begin
         width_sat = 32'd2;
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         width_sat = 32'(MAX_WIDTH);
      end else begin
         width_sat = 32'(width_ff);
      end
      priority if (height_ff < 13'd2) begin
         height_sat = 32'd2;
      end else if (32'(height_ff) > 32'(MAX_HEIGHT)) begin
         height_sat = 32'(MAX_HEIGHT);
      end else begin
         height_sat = 32'(height_ff);
      end
   end

   assign last_col = CW'(width_sat - 32'd1);
   assign last_row = RW'(height_sat - 32'd1);

   get_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .restart    (restart),
      .last_col   (last_col),
      .last_row   (last_row),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .pixel      (req_tdata),
      .push_valid (q_push_valid),
      .push_ready (q_push_ready),
      .push_group (q_push_group)
   );

   get_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (q_push_valid),
      .push_ready (q_push_ready),
      .push_group (q_push_group),
      .pop_valid  (q_pop_valid),
      .pop_ready  (q_pop_ready),
      .pop_group  (q_pop_group)
   );

   get_back u_back (
      .clock      (clock),
      .reset      (reset),
      .threshold  (threshold_ff),
      .pop_valid  (q_pop_valid),
      .pop_ready  (q_pop_ready),
      .pop_group  (q_pop_group),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   a_push_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_push_valid |-> (q_push_group.count != 2'd0))
      else $error("empty result group pushed");

   a_frame_end_col: assert property (@(posedge clock) disable iff (reset)
      (q_push_valid && (q_push_group.count == 2'd3)) |->
         (q_push_group.res[2].col == q_push_group.res[0].col))
      else $error("frame end result off the column above");

   a_last_row_pair: assert property (@(posedge clock) disable iff (reset)
      (q_push_valid && (q_push_group.count != 2'd1)) |->
         (q_push_group.res[1].row == OUT_ROW_W'(q_push_group.res[0].row + 1'b1)))
      else $error("last row result not below the row above");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

// File: test/edge_result_checker.sv
`timescale 1ns / 1ps
// Checker for gradient_edge_threshold: watches the pixel, result and csr ports,
// predicts every result from its own line store and flags each mismatch.
// Depends on get_pkg for field widths, reset values and register indexes.
module edge_result_checker #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,
   input  logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic [31:0] csr_prdata,
   input  logic        csr_pready,
   output int          mismatches,
   output int          pending
);
   import get_pkg::*;

   typedef struct packed {
      logic [OUT_COL_W-1:0] col;
      logic [OUT_ROW_W-1:0] row;
      logic [PIX_W-1:0]     hmag;
      logic                 edge_h;
      logic                 edge_v;
      logic                 edge_any;
      logic                 last;
   } edge_result_type;

   edge_result_type results_due [$];

   logic [PIX_W-1:0] pix_store [0:2*MAX_WIDTH-1];
   logic [7:0]       thr_reg;
   logic [10:0]      width_reg;
   logic [12:0]      height_reg;
   int unsigned      at_col;
   int unsigned      at_row;
   logic [PIX_W-1:0] prev_pix;
   logic [PIX_W-1:0] prev2_pix;

   function automatic int unsigned store_slot(input int unsigned row, input int unsigned col);
      return (row % 2) * MAX_WIDTH + col;
   endfunction

   function automatic int unsigned dist8(input int unsigned a, input int unsigned b);
      return (a >= b) ? a - b : b - a;
   endfunction

   // one-sided difference on the border columns, halved central one inside
   function automatic int unsigned grad_x(input int unsigned l, input int unsigned m,
                                          input int unsigned r, input int unsigned col,
                                          input int unsigned w);
      if (col == 0) return dist8(r, m);
      if (col == w - 1) return dist8(m, l);
      return dist8(r, l) >> 1;
   endfunction

   function automatic edge_result_type make_result(input int unsigned col,
                                                   input int unsigned row,
                                                   input int unsigned hm,
                                                   input int unsigned vm);
      edge_result_type res;
      res.col      = OUT_COL_W'(col);
      res.row      = OUT_ROW_W'(row);
      res.hmag     = PIX_W'(hm);
      res.edge_h   = (hm > thr_reg);
      res.edge_v   = (vm > thr_reg);
      res.edge_any = res.edge_h | res.edge_v;
      res.last     = 1'b0;
      return res;
   endfunction

   task automatic predict_pixel(input logic [PIX_W-1:0] pix);
      int unsigned w, h, c, r, n, left, mid, right, vm;
      edge_result_type made [3];
      w = (width_reg < 2) ? 2 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
      h = (height_reg < 2) ? 2 : ((height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg);
      c = at_col;
      r = at_row;
      n = 0;
      if (c >= w || r >= h) begin
         c = 0;
         r = 0;
      end
      // pixel directly above the incoming one
      if (r >= 1) begin
         mid   = pix_store[store_slot(r - 1, c)];
         left  = (c > 0) ? pix_store[store_slot(r - 1, c - 1)] : 0;
         right = (c + 1 < w) ? pix_store[store_slot(r - 1, c + 1)] : 0;
         if (r == 1)
            vm = dist8(pix, mid);
         else
            vm = dist8(pix, pix_store[store_slot(r - 2, c)]) >> 1;
         made[n] = make_result(c, r - 1, grad_x(left, mid, right, c, w), vm);
         n++;
      end
      pix_store[store_slot(r, c)] = pix;
      // last row: the pixel to the left is complete now
      if (r == h - 1 && c >= 1) begin
         left = (c >= 2) ? prev2_pix : 0;
         vm   = dist8(prev_pix, pix_store[store_slot(r - 1, c - 1)]);
         made[n] = make_result(c - 1, r, grad_x(left, prev_pix, pix, c - 1, w), vm);
         n++;
      end
      if (r == h - 1 && c == w - 1) begin
         made[n] = make_result(c, r, dist8(pix, prev_pix),
                               dist8(pix, pix_store[store_slot(r - 1, c)]));
         n++;
      end
      prev2_pix = prev_pix;
      prev_pix  = pix;
      c++;
      if (c >= w) begin
         c = 0;
         r++;
         if (r >= h) r = 0;
      end
      at_col = c;
      at_row = r;
      for (int i = 0; i < n; i++) begin
         made[i].last = (i == n - 1);
         results_due.push_back(made[i]);
      end
   endtask

   task automatic check_field(input string name, input int unsigned want_v,
                              input int unsigned got_v);
      if (want_v != got_v) begin
         $error("%s: expected %0d, got %0d", name, want_v, got_v);
         mismatches++;
      end
   endtask

   initial begin
      mismatches = 0;
      pending    = 0;
   end

   always @(posedge clock) begin
      edge_result_type seen, want;
      if (reset) begin
         thr_reg    = THRESHOLD_RESET;
         width_reg  = WIDTH_RESET;
         height_reg = HEIGHT_RESET;
         at_col     = 0;
         at_row     = 0;
         prev_pix   = '0;
         prev2_pix  = '0;
         results_due.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               case (csr_paddr[3:2])
                  REG_EDGE_THRESHOLD: thr_reg = csr_pwdata[7:0];
                  REG_IMAGE_WIDTH: begin
                     width_reg = csr_pwdata[10:0];
                     at_col    = 0;
                     at_row    = 0;
                  end
                  REG_IMAGE_HEIGHT: begin
                     height_reg = csr_pwdata[12:0];
                     at_col     = 0;
                     at_row     = 0;
                  end
                  default: ;
               endcase
            end else begin
               case (csr_paddr[3:2])
                  REG_EDGE_THRESHOLD: check_field("edge_threshold", thr_reg, csr_prdata);
                  REG_IMAGE_WIDTH:    check_field("image_width", width_reg, csr_prdata);
                  REG_IMAGE_HEIGHT:   check_field("image_height", height_reg, csr_prdata);
                  default: ;
               endcase
            end
         end
         if (req_tvalid && req_tready) predict_pixel(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            seen.col      = rsp_tdata[9:0];
            seen.row      = rsp_tdata[21:10];
            seen.hmag     = rsp_tdata[29:22];
            seen.edge_h   = rsp_tdata[30];
            seen.edge_v   = rsp_tdata[31];
            seen.edge_any = rsp_tdata[32];
            seen.last     = rsp_tlast;
            if (results_due.size() == 0) begin
               $error("unexpected result transfer for col %0d row %0d", seen.col, seen.row);
               mismatches++;
            end else begin
               want = results_due.pop_front();
               check_field("out_col", want.col, seen.col);
               check_field("out_row", want.row, seen.row);
               check_field("horizontal_magnitude", want.hmag, seen.hmag);
               check_field("edge_horizontal", want.edge_h, seen.edge_h);
               check_field("edge_vertical", want.edge_v, seen.edge_v);
               check_field("edge_either", want.edge_any, seen.edge_any);
               check_field("last_of_run", want.last, seen.last);
            end
         end
      end
      pending = results_due.size();
   end

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// Testbench top for gradient_edge_threshold: clock, reset, pixel and csr stimulus,
// result-side stalls, watchdog and verdict. Depends on get_pkg and edge_result_checker.
module tb;
   import get_pkg::*;

   localparam int MAX_WIDTH      = 1024;
   localparam int MAX_HEIGHT     = 4096;
   localparam int RANDOM_ITEMS   = 450;
   localparam int SETTLE_CYCLES  = 8;
   localparam int WATCHDOG_LIMIT = 2000;

   localparam logic       CSR_READ   = 1'b0;
   localparam logic       CSR_WRITE  = 1'b1;
   localparam logic [1:0] REG_UNUSED = 2'd3;

   typedef enum {STALL_NONE, STALL_COIN, STALL_HEAVY, STALL_PERIODIC} stall_mode_type;
   typedef enum {TEXTURE_NOISE, TEXTURE_STEP} texture_type;

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata   = '0;   // [7:0] grey_level
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   // [9:0] out_col, [21:10] out_row, [29:22] horizontal_magnitude,
   // [30] edge_horizontal, [31] edge_vertical, [32] edge_either, [39:33] zero
   logic [39:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [3:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int mismatches;
   int pending;

   stall_mode_type stall_mode  = STALL_NONE;
   texture_type    texture     = TEXTURE_NOISE;
   int             stall_tick  = 0;
   int             gap_max     = 0;
   int             burst_left  = 0;
   int             cur_thr     = 50;
   int             step_lo     = 0;
   int             step_gap    = 0;
   int             frame_w     = 2;
   int             frame_h     = 2;
   int             idle_cycles = 0;

   gradient_edge_threshold #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_HEIGHT(MAX_HEIGHT)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   edge_result_checker #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_HEIGHT(MAX_HEIGHT)
   ) u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready),
      .mismatches (mismatches),
      .pending    (pending)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   always @(negedge clock) begin
      stall_tick <= stall_tick + 1;
      case (stall_mode)
         STALL_NONE:  rsp_tready <= 1'b1;
         STALL_COIN:  rsp_tready <= $urandom_range(0, 1);
         STALL_HEAVY: rsp_tready <= ($urandom_range(0, 3) == 0);
         default:     rsp_tready <= (stall_tick % 5 < 2);
      endcase
   end

   // count cycles with no transfer on any port
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // entered and left at a falling edge
   task automatic csr_access(input logic wr, input logic [1:0] idx, input logic [31:0] value);
      csr_psel   <= 1'b1;
      csr_pwrite <= wr;
      csr_paddr  <= {idx, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   task automatic read_back_registers();
      csr_access(CSR_READ, REG_EDGE_THRESHOLD, '0);
      csr_access(CSR_READ, REG_IMAGE_WIDTH, '0);
      csr_access(CSR_READ, REG_IMAGE_HEIGHT, '0);
   endtask

   // hold valid through a burst, drop it for a random gap between bursts
   task automatic send_pixel(input logic [7:0] pix);
      int gap;
      if (burst_left == 0) begin
         gap        = $urandom_range(0, gap_max);
         burst_left = $urandom_range(1, 16);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pix;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      burst_left--;
   endtask

   // wait until every result is out and any first-row work has drained
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic logic [7:0] next_pixel();
      if (texture == TEXTURE_STEP)
         return 8'($urandom_range(0, 1) ? step_lo + step_gap : step_lo);
      return 8'($urandom_range(0, 255));
   endfunction

   // step heights put magnitudes right at the threshold, one-sided or halved
   task automatic pick_traffic();
      int k;
      gap_max    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      stall_mode = stall_mode_type'($urandom_range(0, 3));
      texture    = ($urandom_range(0, 2) == 0) ? TEXTURE_STEP : TEXTURE_NOISE;
      k          = $urandom_range(0, 3);
      step_gap   = (k < 2) ? cur_thr + k : 2 * cur_thr + k - 2;
      if (step_gap > 255) step_gap = 255;
      step_lo    = $urandom_range(0, 255 - step_gap);
   endtask

   initial begin
      int random_sent, npix, frame, w_raw, h_raw;
      bit resized;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      read_back_registers();

      // reset geometry: first-row pixels only, nothing comes out
      gap_max = 2;
      send_pixel(8'd0);
      send_pixel(8'd255);
      settle();

      // 3 x 3 frame, threshold 0 marks every nonzero magnitude, then wrap into the next frame
      csr_access(CSR_WRITE, REG_EDGE_THRESHOLD, 32'd0);
      csr_access(CSR_WRITE, REG_IMAGE_WIDTH, 32'd3);
      csr_access(CSR_WRITE, REG_IMAGE_HEIGHT, 32'd3);
      stall_mode = STALL_COIN;
      send_pixel(8'd0);   send_pixel(8'd255); send_pixel(8'd0);
      send_pixel(8'd255); send_pixel(8'd0);   send_pixel(8'd255);
      send_pixel(8'd0);   send_pixel(8'd255); send_pixel(8'd128);
      send_pixel(8'd255); send_pixel(8'd255); send_pixel(8'd0);
      settle();

      // sizes below the minimum clamp to 2 x 2
      csr_access(CSR_WRITE, REG_EDGE_THRESHOLD, 32'd254);
      csr_access(CSR_WRITE, REG_IMAGE_WIDTH, 32'd1);
      csr_access(CSR_WRITE, REG_IMAGE_HEIGHT, 32'd0);
      send_pixel(8'd0); send_pixel(8'd255); send_pixel(8'd255); send_pixel(8'd0);
      settle();

      // write past the register list is dropped
      csr_access(CSR_WRITE, REG_UNUSED, 32'hFFFF_FFFF);
      read_back_registers();

      // upper write bits are masked off; threshold 255 never marks an edge
      csr_access(CSR_WRITE, REG_EDGE_THRESHOLD, 32'hFFFF_FFFF);
      csr_access(CSR_WRITE, REG_IMAGE_WIDTH, 32'hFFFF_F802);
      csr_access(CSR_WRITE, REG_IMAGE_HEIGHT, 32'hFFFF_E002);
      cur_thr = 255;
      send_pixel(8'd255); send_pixel(8'd0); send_pixel(8'd0); send_pixel(8'd255);
      settle();
      read_back_registers();

      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         settle();
         if ($urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 3))
               0:       cur_thr = 0;
               1:       cur_thr = 255;
               default: cur_thr = $urandom_range(0, 255);
            endcase
            csr_access(CSR_WRITE, REG_EDGE_THRESHOLD, ($urandom & 32'hFFFF_FF00) | cur_thr);
         end
         pick_traffic();
         resized = (random_sent == 0) || ($urandom_range(0, 4) != 0);
         if (resized) begin
            if ($urandom_range(0, 9) == 0)
               w_raw = $urandom_range(0, 1);
            else if ($urandom_range(0, 4) == 0)
               w_raw = $urandom_range(7, 40);
            else
               w_raw = $urandom_range(2, 6);
            if ($urandom_range(0, 9) == 0)
               h_raw = $urandom_range(0, 1);
            else if ($urandom_range(0, 4) == 0)
               h_raw = $urandom_range(6, 12);
            else
               h_raw = $urandom_range(2, 5);
            frame_w = (w_raw < 2) ? 2 : w_raw;
            frame_h = (h_raw < 2) ? 2 : h_raw;
            csr_access(CSR_WRITE, REG_IMAGE_WIDTH, ($urandom & 32'hFFFF_F800) | w_raw);
            csr_access(CSR_WRITE, REG_IMAGE_HEIGHT, ($urandom & 32'hFFFF_E000) | h_raw);
         end
         if ($urandom_range(0, 3) == 0) read_back_registers();
         frame = frame_w * frame_h;
         if (resized) begin
            npix = $urandom_range(1, 2) * frame;
            // cut some frames short so the next size write lands mid-frame
            if ($urandom_range(0, 2) == 0) npix += $urandom_range(1, frame - 1);
         end else begin
            npix = $urandom_range(1, 2 * frame);
         end
         repeat (npix) send_pixel(next_pixel());
         random_sent += npix;
      end

      // widest frame, width written above range: a first-row run only
      settle();
      cur_thr = $urandom_range(0, 255);
      csr_access(CSR_WRITE, REG_EDGE_THRESHOLD, 32'(cur_thr));
      csr_access(CSR_WRITE, REG_IMAGE_WIDTH, 32'h0000_07FF);
      csr_access(CSR_WRITE, REG_IMAGE_HEIGHT, 32'd2);
      pick_traffic();
      repeat (16) send_pixel(next_pixel());

      // tallest frame, two columns, height written above range: top rows only
      settle();
      csr_access(CSR_WRITE, REG_IMAGE_WIDTH, 32'd2);
      csr_access(CSR_WRITE, REG_IMAGE_HEIGHT, 32'h0000_1FFF);
      pick_traffic();
      repeat (24) send_pixel(next_pixel());

      // exact maxima, a few first-row pixels
      settle();
      csr_access(CSR_WRITE, REG_IMAGE_WIDTH, 32'(MAX_WIDTH));
      csr_access(CSR_WRITE, REG_IMAGE_HEIGHT, 32'(MAX_HEIGHT));
      read_back_registers();
      repeat (5) send_pixel(next_pixel());

      settle();
      if (mismatches == 0 && pending == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/get_pkg.sv
rtl/get_front.sv
rtl/get_queue.sv
rtl/get_back.sv
rtl/gradient_edge_threshold.sv
test/edge_result_checker.sv
test/tb.sv
